>>> design/jsu_pkg.sv
// Shared types and codes for the JSON string unescaper.
// Depends on nothing; the front, queue, back and top files import it.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

   // Error codes carried on the result channel.
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_NO_QUOTE   = 3'd1;
   localparam logic [2:0] ERR_BAD_ESCAPE = 3'd2;
   localparam logic [2:0] ERR_BAD_HEX    = 3'd3;
   localparam logic [2:0] ERR_BAD_LOW    = 3'd4;
   localparam logic [2:0] ERR_TRUNC      = 3'd5;
   localparam logic [2:0] ERR_UNTERM     = 3'd6;

   // All results caused by one text byte. Slot 0 goes out first; done and
   // err belong to the final result only.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      cnt_m1;
      logic            done;
      logic [2:0]      err;
   } job_type;

   // One job moving between the front, the queue and the back.
   typedef struct packed {
      logic    valid;
      job_type job;
   } job_xfer_type;

endpackage

`default_nettype wire

>>> design/jsu_channels.sv
// Valid/ready channel interfaces for text bytes in and decoded results out.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       text_ends;

   modport source (output valid, output in_byte, output text_ends, input ready);
   modport sink   (input valid, input in_byte, input text_ends, output ready);
endinterface

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       string_done;
   logic [2:0] error_code;
   logic       last;

   modport source (output valid, output out_byte, output string_done,
                   output error_code, output last, input ready);
   modport sink   (input valid, input out_byte, input string_done,
                   input error_code, input last, output ready);
endinterface

`default_nettype wire

>>> design/jsu_front.sv
// Front end: accepts text bytes, runs the string parser and builds one job
// of up to four results per byte. Depends on jsu_pkg and jsu_channels.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
   input  wire logic            clock,
   input  wire logic            reset,
   jsu_req_if.sink              req_bus,
   input  wire logic            push_ready,
   output jsu_pkg::job_xfer_type push_out
);
   import jsu_pkg::*;

   typedef enum logic [6:0] {
      PH_WAIT     = 7'b0000001,
      PH_STR      = 7'b0000010,
      PH_ESC      = 7'b0000100,
      PH_HEX      = 7'b0001000,
      PH_HELD     = 7'b0010000,
      PH_HELD_ESC = 7'b0100000,
      PH_LOWHEX   = 7'b1000000
   } phase_type;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_U      = 8'h75;

   // UTF-8 for a 16-bit code point, one to three bytes.
   function automatic job_type enc16(input logic [15:0] cp);
      job_type j;
      j = '0;
      if (cp[15:7] == 9'd0) begin
         j.bytes[0] = cp[7:0];
         j.cnt_m1   = 2'd0;
      end else if (cp[15:11] == 5'd0) begin
         j.bytes[0] = {3'b110, cp[10:6]};
         j.bytes[1] = {2'b10, cp[5:0]};
         j.cnt_m1   = 2'd1;
      end else begin
         j.bytes[0] = {4'b1110, cp[15:12]};
         j.bytes[1] = {2'b10, cp[11:6]};
         j.bytes[2] = {2'b10, cp[5:0]};
         j.cnt_m1   = 2'd2;
      end
      return j;
   endfunction

   // UTF-8 for a surrogate pair, always four bytes.
   function automatic job_type enc_pair(input logic [15:0] hi, input logic [15:0] lo);
      job_type     j;
      logic [20:0] cp;
      j = '0;
      cp = {1'b0, hi[9:0], lo[9:0]} + 21'h10000;
      j.bytes[0] = {5'b11110, cp[20:18]};
      j.bytes[1] = {2'b10, cp[17:12]};
      j.bytes[2] = {2'b10, cp[11:6]};
      j.bytes[3] = {2'b10, cp[5:0]};
      j.cnt_m1   = 2'd3;
      return j;
   endfunction

   phase_type   phase_ff, phase_in;
   logic [15:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [15:0] held_ff, held_in;

   logic        accept;
   logic        is_quote, is_bslash, is_u, is_space;
   logic        esc_ok;
   logic [7:0]  esc_val;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] acc_shift;
   job_type     held_pre;
   job_type     job;
   logic        emit;
   logic [2:0]  err;

   assign req_bus.ready = push_ready;
   assign accept        = req_bus.valid && push_ready;

   // Byte classes.
   assign is_quote  = (req_bus.in_byte == CH_QUOTE);
   assign is_bslash = (req_bus.in_byte == CH_BSLASH);
   assign is_u      = (req_bus.in_byte == CH_U);
   assign is_space  = (req_bus.in_byte == CH_SPACE) || (req_bus.in_byte inside {[8'h09:8'h0d]});

   // Single-character escapes.
   always_comb begin
      esc_ok  = 1'b1;
      esc_val = req_bus.in_byte;
      case (req_bus.in_byte)
         CH_QUOTE, CH_BSLASH, CH_SLASH: esc_val = req_bus.in_byte;
         8'h62:   esc_val = 8'h08;
         8'h66:   esc_val = 8'h0c;
         8'h6e:   esc_val = 8'h0a;
         8'h72:   esc_val = 8'h0d;
         8'h74:   esc_val = 8'h09;
         default: esc_ok = 1'b0;
      endcase
   end

   // Hex digit value.
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (req_bus.in_byte inside {[8'h30:8'h39]}) begin
         hex_val = 4'(req_bus.in_byte - 8'h30);
      end else if (req_bus.in_byte inside {[8'h61:8'h66]}) begin
         hex_val = 4'(req_bus.in_byte - 8'h57);
      end else if (req_bus.in_byte inside {[8'h41:8'h46]}) begin
         hex_val = 4'(req_bus.in_byte - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign acc_shift = {acc_ff[11:0], hex_val};

   // Held high surrogate as three bytes, with room for one more result.
   always_comb begin
      held_pre        = enc16(held_ff);
      held_pre.cnt_m1 = 2'd3;
   end

   // Parser step for the byte on the request channel.
   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      held_in  = held_ff;
      job      = '0;
      emit     = 1'b0;
      err      = ERR_NONE;
      case (phase_ff)
         PH_WAIT: begin
            if (is_quote) begin
               phase_in = PH_STR;
            end else if (!is_space || req_bus.text_ends) begin
               err = ERR_NO_QUOTE;
            end
         end
         PH_STR: begin
            emit         = !is_bslash;
            job.bytes[0] = is_quote ? 8'h00 : req_bus.in_byte;
            job.done     = is_quote;
            if (is_quote) begin
               phase_in = PH_WAIT;
            end else if (is_bslash) begin
               phase_in = PH_ESC;
            end
         end
         PH_ESC: begin
            if (is_u) begin
               phase_in = PH_HEX;
               acc_in   = '0;
               cnt_in   = '0;
            end else if (esc_ok) begin
               emit         = 1'b1;
               job.bytes[0] = esc_val;
               phase_in     = PH_STR;
            end else begin
               err = ERR_BAD_ESCAPE;
            end
         end
         PH_HEX, PH_LOWHEX: begin
            if (req_bus.text_ends && cnt_ff != 2'd3) begin
               err = ERR_TRUNC;
            end else if (!hex_ok) begin
               err = ERR_BAD_HEX;
            end else if (cnt_ff != 2'd3) begin
               acc_in = acc_shift;
               cnt_in = cnt_ff + 2'd1;
            end else begin
               acc_in = '0;
               cnt_in = '0;
               if (phase_ff == PH_HEX) begin
                  if (acc_shift[15:10] == 6'b110110) begin
                     held_in  = acc_shift;
                     phase_in = PH_HELD;
                  end else begin
                     emit     = 1'b1;
                     job      = enc16(acc_shift);
                     phase_in = PH_STR;
                  end
               end else if (acc_shift[15:10] != 6'b110111) begin
                  err = ERR_BAD_LOW;
               end else begin
                  emit     = 1'b1;
                  job      = enc_pair(held_ff, acc_shift);
                  held_in  = '0;
                  phase_in = PH_STR;
               end
            end
         end
         PH_HELD: begin
            if (is_bslash) begin
               phase_in = PH_HELD_ESC;
            end else begin
               // The unpaired surrogate goes out first, then this byte.
               emit         = 1'b1;
               job          = held_pre;
               job.bytes[3] = is_quote ? 8'h00 : req_bus.in_byte;
               job.done     = is_quote;
               held_in      = '0;
               phase_in     = is_quote ? PH_WAIT : PH_STR;
            end
         end
         PH_HELD_ESC: begin
            if (is_u) begin
               phase_in = PH_LOWHEX;
               acc_in   = '0;
               cnt_in   = '0;
            end else if (esc_ok) begin
               emit         = 1'b1;
               job          = held_pre;
               job.bytes[3] = esc_val;
               held_in      = '0;
               phase_in     = PH_STR;
            end else begin
               err = ERR_BAD_ESCAPE;
            end
         end
         default: begin
            phase_in = PH_WAIT;
         end
      endcase

      // Text that stops inside a string.
      if (err == ERR_NONE && req_bus.text_ends && phase_in != PH_WAIT) begin
         err = (phase_in == PH_HEX || phase_in == PH_LOWHEX) ? ERR_TRUNC : ERR_UNTERM;
      end

      // An error is the only result of its byte.
      if (err != ERR_NONE) begin
         job      = '0;
         job.err  = err;
         emit     = 1'b1;
         phase_in = PH_WAIT;
      end

      // Every return to waiting starts from a clean state.
      if (phase_in == PH_WAIT) begin
         acc_in  = '0;
         cnt_in  = '0;
         held_in = '0;
      end
   end

   // Parser state advances on each accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_WAIT;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         held_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         held_ff  <= held_in;
      end
   end

   assign push_out.valid = accept && emit;
   assign push_out.job   = job;

endmodule

`default_nettype wire

>>> design/jsu_queue.sv
// Short job queue between the parser front and the result back end.
// Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  jsu_pkg::job_xfer_type push_in,
   output logic                  push_ready,
   output jsu_pkg::job_xfer_type head_out,
   input  wire logic             pop
);
   import jsu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          slots_ff [DEPTH];
   logic [PTR_W-1:0] wptr_ff, wptr_in;
   logic [PTR_W-1:0] rptr_ff, rptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready     = (count_ff != CNT_FULL);
   assign head_out.valid = (count_ff != '0);
   assign head_out.job   = slots_ff[rptr_ff];

   assign do_push = push_in.valid && push_ready;
   assign do_pop  = pop && head_out.valid;

   // Pointer and fill-count update.
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_LAST) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_LAST) ? '0 : rptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wptr_ff] <= push_in.job;
      end
   end

endmodule

`default_nettype wire

>>> design/jsu_back.sv
// Back end: takes jobs from the queue and sends their results one transfer
// per cycle on the result channel while it is ready. Depends on jsu_pkg and jsu_channels.
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  jsu_pkg::job_xfer_type head_in,
   output logic                  pop,
   jsu_rsp_if.source             rsp_bus
);
   import jsu_pkg::*;

   logic       busy_ff;
   job_type    job_ff;
   logic [1:0] idx_ff;
   logic       take;
   logic       is_last;

   assign is_last = (idx_ff == job_ff.cnt_m1);
   assign take    = busy_ff && rsp_bus.ready;
   assign pop     = head_in.valid && (!busy_ff || (take && is_last));

   // Result fields come straight from the held job.
   assign rsp_bus.valid       = busy_ff;
   assign rsp_bus.out_byte    = job_ff.bytes[idx_ff];
   assign rsp_bus.string_done = is_last && job_ff.done;
   assign rsp_bus.error_code  = is_last ? job_ff.err : ERR_NONE;
   assign rsp_bus.last        = is_last;

   // Step through the slots; load the next job as the last one leaves.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (pop) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (take && is_last) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (take) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head_in.job;
      end
   end

endmodule

`default_nettype wire

>>> design/json_string_unescape_utf8.sv
// JSON string unescaper to UTF-8: top level joining front, queue and back.
// Depends on jsu_pkg, jsu_channels, jsu_front, jsu_queue and jsu_back.
//
// Feed JSON text one byte per transfer on req_bus, marking the final byte
// with text_ends; leading whitespace is skipped, then the string between
// quotes is unescaped and each decoded UTF-8 byte leaves on rsp_bus, with a
// done result at the closing quote or a single error result, after which
// the block waits for a new opening quote. A byte is accepted every cycle
// while the job queue (QUEUE_DEPTH jobs) has room; each byte causes zero to
// four results and the back end sends one result per cycle while rsp_bus
// is ready, so plain text then runs at one byte per cycle, and the results
// of a byte that expands to more than one result leave one after another.
// The first result of a byte is registered in the queue and then in the
// back end before it is valid on rsp_bus.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8 #(
   parameter int QUEUE_DEPTH = 2
) (
   input wire logic clock,
   input wire logic reset,
   jsu_req_if.sink   req_bus,
   jsu_rsp_if.source rsp_bus
);
   import jsu_pkg::*;

   job_xfer_type push;
   job_xfer_type head;
   logic         q_ready;
   logic         pop;

   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push_ready (q_ready),
      .push_out   (push)
   );

   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_in    (push),
      .push_ready (q_ready),
      .head_out   (head),
      .pop        (pop)
   );

   jsu_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head_in (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

`ifndef SYNTHESIS
   // A job is only offered when the queue can take it.
   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> q_ready)
      else $error("job offered to a full queue");

   // Done and error results always close the results of their byte.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.string_done || rsp_bus.error_code != ERR_NONE)
      |-> rsp_bus.last)
      else $error("status result not marked last");

   // An error result carries no byte and no done flag.
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.error_code != ERR_NONE
      |-> (rsp_bus.out_byte == 8'h00) && !rsp_bus.string_done)
      else $error("error result carries data");

   // A result still waiting keeps its position in the job.
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready |=> rsp_bus.valid && $stable(rsp_bus.last))
      else $error("stalled result moved");
`endif

endmodule

`default_nettype wire
